>>> rtl/hsd_pkg.sv
// Shared types, constants and helpers for the hall sensor decoder.
package hsd_pkg;

    localparam int COUNTER_WIDTH = 32;

    localparam int STAMP_W    = 32;
    localparam int VALUE_W    = 32;
    localparam int CODE_W     = 3;
    localparam int MODE_W     = 2;
    localparam int DIR_W      = 2;
    localparam int EPR_W      = 8;
    localparam int SCALE_W    = 6;
    localparam int RPM_SCALE  = 60;
    localparam int NUM_W      = STAMP_W + SCALE_W;
    localparam int DEN_W      = VALUE_W + EPR_W;
    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam int FILT_W     = ((COUNTER_WIDTH > VALUE_W + 2) ? COUNTER_WIDTH : VALUE_W + 2) + 1;

    localparam int IN_FIELDS_W  = MODE_W + CODE_W + STAMP_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = CODE_W + 4 + DIR_W + 6 * VALUE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_HZ  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDGES_REV = 1'b1;
    localparam logic [VALUE_W-1:0]     TIMER_HZ_RST  = 32'd168000000;
    localparam logic [EPR_W-1:0]       EDGES_REV_RST = 8'd24;

    localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INIT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [DIR_W-1:0] DIR_NONE    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd2;
    localparam logic [DIR_W-1:0] DIR_JUMP    = 2'd3;

    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_CLEAR,
        OP_TIME
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CODE_W-1:0]  hall_code;
        logic               state_changed;
        logic               code_valid;
        logic               step_valid;
        logic               shutdown_request;
        logic [DIR_W-1:0]   direction;
        logic [VALUE_W-1:0] edge_total;
        logic [VALUE_W-1:0] forward_total;
        logic [VALUE_W-1:0] reverse_total;
        logic [VALUE_W-1:0] jump_total;
        logic [STAMP_W-1:0] timestamp;
    } entry_t;

    // six-step forward sequence 1->3->2->6->4->5->1
    function automatic logic [CODE_W-1:0] fwd_next(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] r;
        case (code)
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd6;
            3'd3:    r = 3'd2;
            3'd4:    r = 3'd5;
            3'd5:    r = 3'd1;
            3'd6:    r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic code_ok(input logic [CODE_W-1:0] code);
        return (code != 3'd0) && (code != 3'd7);
    endfunction

endpackage

>>> rtl/hsd_front.sv
// Front end: takes input words, classifies hall transitions and keeps the step counters.
module hsd_front import hsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  q_full,
    output logic                  push,
    output entry_t                push_entry
);

    logic [CODE_W-1:0]  prev_code_reg, prev_code_next;
    logic [VALUE_W-1:0] edge_reg, edge_next;
    logic [VALUE_W-1:0] fwd_cnt_reg, fwd_cnt_next;
    logic [VALUE_W-1:0] rev_reg, rev_next;
    logic [VALUE_W-1:0] jump_reg, jump_next;

    logic [MODE_W-1:0]  mode;
    logic [CODE_W-1:0]  code;
    logic [CODE_W-1:0]  diff;
    logic [STAMP_W-1:0] stamp;
    logic               one_bit;
    logic               accept;

    assign mode  = s_axis_tdata[MODE_W-1:0];
    assign code  = ~s_axis_tdata[MODE_W+CODE_W-1:MODE_W];
    assign stamp = s_axis_tdata[IN_FIELDS_W-1:MODE_W+CODE_W];
    assign diff  = code ^ prev_code_reg;
    assign one_bit = (diff == 3'b001) || (diff == 3'b010) || (diff == 3'b100);

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign push          = accept;

    always_comb
    begin
        prev_code_next = prev_code_reg;
        edge_next      = edge_reg;
        fwd_cnt_next   = fwd_cnt_reg;
        rev_next       = rev_reg;
        jump_next      = jump_reg;

        push_entry                  = '0;
        push_entry.op               = OP_NONE;
        push_entry.timestamp        = stamp;
        push_entry.hall_code        = prev_code_reg;
        push_entry.direction        = DIR_NONE;

        case (mode)
            MODE_EDGE:
            begin
                push_entry.hall_code = code;
                if (code != prev_code_reg)
                begin
                    push_entry.state_changed = 1'b1;
                    push_entry.step_valid    = one_bit;
                    edge_next                = edge_reg + 1'b1;
                    prev_code_next           = code;
                    if (!code_ok(code) || !one_bit)
                    begin
                        jump_next                   = jump_reg + 1'b1;
                        push_entry.shutdown_request = 1'b1;
                        push_entry.direction        = DIR_JUMP;
                    end
                    else
                    begin
                        push_entry.op = OP_TIME;
                        if (code == fwd_next(prev_code_reg))
                        begin
                            fwd_cnt_next         = fwd_cnt_reg + 1'b1;
                            push_entry.direction = DIR_FORWARD;
                        end
                        else if (prev_code_reg == fwd_next(code))
                        begin
                            rev_next             = rev_reg + 1'b1;
                            push_entry.direction = DIR_REVERSE;
                        end
                        else
                        begin
                            jump_next            = jump_reg + 1'b1;
                            push_entry.direction = DIR_JUMP;
                        end
                    end
                end
            end
            MODE_INIT:
            begin
                edge_next             = '0;
                fwd_cnt_next          = '0;
                rev_next              = '0;
                jump_next             = '0;
                prev_code_next        = code;
                push_entry.hall_code  = code;
                push_entry.step_valid = 1'b1;
                push_entry.op         = OP_CLEAR;
            end
            MODE_CLEAR:
            begin
                push_entry.op = OP_CLEAR;
            end
            default:
            begin
                push_entry.op = OP_NONE;
            end
        endcase

        push_entry.code_valid    = code_ok(push_entry.hall_code);
        push_entry.edge_total    = edge_next;
        push_entry.forward_total = fwd_cnt_next;
        push_entry.reverse_total = rev_next;
        push_entry.jump_total    = jump_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_code_reg <= '0;
            edge_reg      <= '0;
            fwd_cnt_reg   <= '0;
            rev_reg       <= '0;
            jump_reg      <= '0;
        end
        else if (accept)
        begin
            prev_code_reg <= prev_code_next;
            edge_reg      <= edge_next;
            fwd_cnt_reg   <= fwd_cnt_next;
            rev_reg       <= rev_next;
            jump_reg      <= jump_next;
        end
    end

endmodule

>>> rtl/hsd_queue.sv
// Short FIFO of classified words between the front end and the speed unit.
module hsd_queue import hsd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   pop_valid,
    output entry_t pop_entry
);

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/hsd_back.sv
// Speed unit: period filter, serial rpm divider and the output register.
module hsd_back import hsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  entry_t                 q_entry,
    output logic                   q_pop,
    input  logic [VALUE_W-1:0]     timer_hz,
    input  logic [EPR_W-1:0]       edges_rev,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_FILT = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_SAT  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    entry_t                   cur_reg, cur_next;
    logic [STAMP_W-1:0]       last_reg, last_next;
    logic [VALUE_W-1:0]       filt_reg, filt_next;
    logic [VALUE_W-1:0]       rpm_reg, rpm_next;
    logic [COUNTER_WIDTH-1:0] period_reg, period_next;
    logic [NUM_W-1:0]         quo_reg, quo_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [DEN_W-1:0]         rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                     m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]   m_data_reg, m_data_next;

    logic [2*STAMP_W-1:0]     stamp_diff;
    logic [FILT_W-1:0]        f_ext;
    logic [FILT_W-1:0]        p_ext;
    logic [FILT_W-1:0]        filt_sum;
    logic [FILT_W-1:0]        filt_new;
    logic [DEN_W:0]           trial;
    logic [DEN_W:0]           trial_sub;
    logic                     trial_ge;
    logic                     out_free;

    assign stamp_diff = {STAMP_W'(0), q_entry.timestamp} - {STAMP_W'(0), last_reg};
    assign f_ext      = FILT_W'(filt_reg);
    assign p_ext      = FILT_W'(period_reg);
    assign filt_sum   = (f_ext << 1) + f_ext + p_ext;
    assign filt_new   = (filt_reg == '0) ? p_ext : (filt_sum >> 2);
    assign trial      = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_sub  = trial - {1'b0, den_reg};
    assign trial_ge   = (trial >= {1'b0, den_reg});
    assign out_free   = !m_valid_reg || m_axis_tready;

    assign q_pop         = (state_reg == ST_IDLE) && q_valid;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        last_next    = last_reg;
        filt_next    = filt_reg;
        rpm_next     = rpm_reg;
        period_next  = period_reg;
        quo_next     = quo_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cur_next   = q_entry;
                    state_next = ST_OUT;
                    case (q_entry.op)
                        OP_CLEAR:
                        begin
                            rpm_next  = '0;
                            last_next = '0;
                            filt_next = '0;
                        end
                        OP_TIME:
                        begin
                            last_next = q_entry.timestamp;
                            if (last_reg != '0)
                            begin
                                period_next = stamp_diff[COUNTER_WIDTH-1:0];
                                state_next  = ST_FILT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_FILT:
            begin
                filt_next  = (filt_new > FILT_W'(VALUE_MAX)) ? VALUE_MAX : filt_new[VALUE_W-1:0];
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                quo_next   = NUM_W'(timer_hz) * NUM_W'(RPM_SCALE);
                den_next   = DEN_W'(edges_rev) * DEN_W'(filt_reg);
                rem_next   = '0;
                cnt_next   = DIV_CNT_W'(NUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (den_reg == '0)
                begin
                    rpm_next   = VALUE_MAX;
                    state_next = ST_OUT;
                end
                else
                begin
                    rem_next = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], trial_ge};
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_SAT;
                    end
                end
            end
            ST_SAT:
            begin
                rpm_next   = (|quo_reg[NUM_W-1:VALUE_W]) ? VALUE_MAX : quo_reg[VALUE_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_TDATA_W'({filt_reg, rpm_reg,
                                                 cur_reg.jump_total, cur_reg.reverse_total,
                                                 cur_reg.forward_total, cur_reg.edge_total,
                                                 cur_reg.direction, cur_reg.shutdown_request,
                                                 cur_reg.step_valid, cur_reg.code_valid,
                                                 cur_reg.state_changed, cur_reg.hall_code});
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            last_reg    <= '0;
            filt_reg    <= '0;
            rpm_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            last_reg    <= last_next;
            filt_reg    <= filt_next;
            rpm_reg     <= rpm_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        period_reg <= period_next;
        quo_reg    <= quo_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
    end

    a_div_den_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && $past(state_reg) == ST_DIV) |-> $stable(den_reg))
        else $error("divisor changed during division");

    a_sat_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SAT) |-> ($past(state_reg) == ST_DIV))
        else $error("saturation step not preceded by division");

    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished result not moved to output register");

endmodule

>>> rtl/hall_sensor_decoder_speed_unit.sv
// Top level of the hall sensor decoder with speed estimate.
//
// Input channel s_axis_*: one word per hall event (mode, active-low pins,
// timestamp). Output channel m_axis_*: one result word per input word,
// in order. Configuration channel cfg_*: index 0 timer clock in Hz, index 1
// hall edges per revolution; always ready, write only while idle.
//
// The front end classifies each word in its accept cycle and keeps the
// edge and step counters; a two-entry queue feeds the speed unit. Words
// without a timed step go from the queue through the idle and output states
// to the output register. A timed step runs the period filter, a multiply
// step, a serial restoring divider for rpm and a saturation step. The
// speed unit pops the next word only after the current one has been
// loaded into the output register.
//
// Reset clears the counters, the speed state and the hall code to zero and
// loads the configuration defaults. A stalled receiver holds the output
// register; the queue keeps accepting until it holds two words.
module hall_sensor_decoder_speed_unit import hsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // mode[1:0], raw_pins[4:2], timestamp[36:5], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // hall_code[2:0], state_changed[3], code_valid[4], step_valid[5],
    // shutdown_request[6], direction[8:7], edge_total[40:9],
    // forward_total[72:41], reverse_total[104:73], jump_total[136:105],
    // speed_rpm[168:137], smoothed_period[200:169], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [VALUE_W-1:0]     cfg_data
);

    logic [VALUE_W-1:0] timer_hz_reg;
    logic [EPR_W-1:0]   edges_rev_reg;
    logic               q_full;
    logic               q_push;
    entry_t             q_push_entry;
    logic               q_pop;
    logic               q_valid;
    entry_t             q_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_hz_reg  <= TIMER_HZ_RST;
            edges_rev_reg <= EDGES_REV_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TIMER_HZ:  timer_hz_reg  <= cfg_data;
                CFG_EDGES_REV: edges_rev_reg <= cfg_data[EPR_W-1:0];
                default:       timer_hz_reg  <= timer_hz_reg;
            endcase
        end
    end

    hsd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .push          (q_push),
        .push_entry    (q_push_entry)
    );

    hsd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    hsd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .q_pop         (q_pop),
        .timer_hz      (timer_hz_reg),
        .edges_rev     (edges_rev_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
